### hdl/isp_pkg.sv
// ----------------------------------------------------------------------------
// isp_pkg
// shared types and constants for the streaming string to integer parser
// ----------------------------------------------------------------------------
package isp_pkg;

  localparam int MAX_LEN = 4096;
  localparam int POS_W   = 13;
  localparam int BASE_W  = 5;
  localparam int VAL_W   = 64;

  localparam logic [POS_W-1:0]  POS_CAP   = POS_W'((MAX_LEN < 8191) ? MAX_LEN : 8191);
  localparam logic [BASE_W-1:0] BASE_RST  = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_AUTO = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_OCT  = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC  = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX  = BASE_W'(16);

  // digit code for characters that are not digits, above any base
  localparam logic [5:0] DIGIT_NONE = 6'h3f;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        end_offset;
  } out_item_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [5:0] d;
    d = DIGIT_NONE;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 6'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = 6'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = 6'(c - 8'h37);
    end
    return d;
  endfunction

endpackage

### hdl/isp_in_stage.sv
// ----------------------------------------------------------------------------
// isp_in_stage
// input register; holds a final character while out_stall is high and the result register is full
// ----------------------------------------------------------------------------
module isp_in_stage
  import isp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     out_busy,
  output logic     item_fire,
  output in_item_t item
);

  logic     valid_r;
  in_item_t item_r;
  logic     blocked;

  assign blocked   = item_r.last & out_busy;
  assign in_stall  = valid_r & blocked;
  assign item_fire = valid_r & ~blocked;
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

### hdl/isp_parse.sv
// ----------------------------------------------------------------------------
// isp_parse
// per-string parse state and combinational character step
// ----------------------------------------------------------------------------
module isp_parse
  import isp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_fire,
  input  in_item_t          item,
  input  logic [BASE_W-1:0] number_base,
  output logic              res_valid,
  output out_item_t         res
);

  localparam logic [2:0] PH_SPACE  = 3'd0;
  localparam logic [2:0] PH_SIGNED = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_DIGITS = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic [BASE_W-1:0] base_r, base_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  stop_r, stop_nxt;

  logic [POS_W-1:0]  pos_inc;
  logic [5:0]        dig;
  logic              is_ws;
  logic              is_sign;
  logic              is_x;
  logic              handled;

  assign pos_inc = (pos_r < POS_CAP) ? pos_r + POS_W'(1) : POS_CAP;
  assign dig     = digit_of(item.ch);
  assign is_ws   = (item.ch == 8'h20) || (item.ch == 8'h09) ||
                   (item.ch == 8'h0a) || (item.ch == 8'h0d);
  assign is_sign = (item.ch == 8'h2d) || (item.ch == 8'h2b);
  assign is_x    = (item.ch == 8'h78) || (item.ch == 8'h58);

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    stop_nxt  = stop_r;
    handled   = 1'b0;

    if (phase_nxt == PH_SPACE) begin
      if (is_ws) begin
        stop_nxt = pos_inc;
        handled  = 1'b1;
      end else if (is_sign) begin
        neg_nxt   = (item.ch == 8'h2d);
        stop_nxt  = pos_inc;
        phase_nxt = PH_SIGNED;
        handled   = 1'b1;
      end else begin
        phase_nxt = PH_SIGNED;
      end
    end

    if (!handled && phase_nxt == PH_SIGNED) begin
      if (item.ch == 8'h30 && (number_base == BASE_AUTO || number_base == BASE_HEX)) begin
        base_nxt  = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        stop_nxt  = pos_inc;
        phase_nxt = PH_ZERO;
        handled   = 1'b1;
      end else begin
        base_nxt  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
        phase_nxt = PH_DIGITS;
      end
    end

    if (!handled && phase_nxt == PH_ZERO) begin
      if (is_x) begin
        base_nxt = BASE_HEX;
        stop_nxt = pos_inc;
        handled  = 1'b1;
      end
      phase_nxt = PH_DIGITS;
    end

    if (!handled && phase_nxt == PH_DIGITS) begin
      if (dig >= {1'b0, base_nxt}) begin
        phase_nxt = PH_DONE;
      end else begin
        acc_nxt  = acc_r * {{(VAL_W-BASE_W){1'b0}}, base_nxt} + {{(VAL_W-6){1'b0}}, dig};
        stop_nxt = pos_inc;
      end
    end

    pos_nxt = pos_inc;
  end

  assign res_valid      = item_fire & item.last;
  assign res.value      = neg_nxt ? (VAL_W'(0) - acc_nxt) : acc_nxt;
  assign res.end_offset = stop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SPACE;
      neg_r   <= 1'b0;
      acc_r   <= '0;
      base_r  <= '0;
      pos_r   <= '0;
      stop_r  <= '0;
    end else if (item_fire) begin
      if (item.last) begin
        phase_r <= PH_SPACE;
        neg_r   <= 1'b0;
        acc_r   <= '0;
        base_r  <= '0;
        pos_r   <= '0;
        stop_r  <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        acc_r   <= acc_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
        stop_r  <= stop_nxt;
      end
    end
  end

  a_stop_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    stop_r <= pos_r)
    else $error("stop offset beyond character position");

  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CAP)
    else $error("character position above cap");

  a_acc_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r != '0) |-> (phase_r == PH_DIGITS || phase_r == PH_DONE))
    else $error("accumulator nonzero before digit phase");

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (item_fire && item.last) |=> (pos_r == '0 && phase_r == PH_SPACE))
    else $error("string state not cleared after final transaction");

endmodule

### hdl/isp_out_stage.sv
// ----------------------------------------------------------------------------
// isp_out_stage
// result register toward the output channel
// ----------------------------------------------------------------------------
module isp_out_stage
  import isp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic      out_busy
);

  logic      valid_r;
  out_item_t data_r;

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_busy  = valid_r & out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      data_r <= res;
    end
  end

endmodule

### hdl/integer_string_parser.sv
// ----------------------------------------------------------------------------
// integer_string_parser
// streaming signed integer parser, one character per transaction
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_stall       in_data  (ch, last)
//  out       output     out_valid / out_stall     out_data (value, end_offset)
//  cfg       input      cfg_wr_en                 cfg_wr_data (number_base)
//
//  one character accepted per cycle while in_stall is low; a result passes from the
//  input register through the parse step into the result register
//  the multiply-add of the accumulator by the base sits between the two registers
//  reset is synchronous; afterward the base is 10 and the parser waits for a string
//  a stalled result holds back only a final character, others keep flowing
// ----------------------------------------------------------------------------
module integer_string_parser
  import isp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [BASE_W-1:0] cfg_wr_data
);

  logic [BASE_W-1:0] number_base_r;
  logic              out_busy;
  logic              item_fire;
  in_item_t          item;
  logic              res_valid;
  out_item_t         res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_RST;
    end else if (cfg_wr_en) begin
      number_base_r <= cfg_wr_data;
    end
  end

  isp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_busy  (out_busy),
    .item_fire (item_fire),
    .item      (item)
  );

  isp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (item_fire),
    .item        (item),
    .number_base (number_base_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  isp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .out_busy  (out_busy)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives character streams into integer_string_parser. A model in the bench
// tracks the parse state and the radix of each string and queues the value and
// offset each string should give. Returned results are checked field by field.
// The run covers directed strings, strings longer than the position limit and
// random strings under several radix settings, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import isp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_X_LO  = "x";
  localparam logic [7:0] CH_X_UP  = "X";
  localparam logic [5:0] NOT_A_DIGIT = 6'h3f;

  typedef enum logic [2:0] {
    SCAN_BLANKS,
    SCAN_SIGNED,
    SCAN_ZERO,
    SCAN_DIGITS,
    SCAN_DONE
  } scan_state_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en = 1'b0;
  logic [BASE_W-1:0] cfg_wr_data = '0;

  // parser model state
  logic [BASE_W-1:0] radix_setting = BASE_RST;
  scan_state_t       scan_state = SCAN_BLANKS;
  logic              minus_seen = 1'b0;
  logic [VAL_W-1:0]  acc = '0;
  logic [BASE_W-1:0] radix = '0;
  logic [POS_W-1:0]  scan_pos = '0;
  logic [POS_W-1:0]  stop_pos = '0;

  out_item_t pending_parses[$];
  out_item_t want;

  int error_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int stall_left = 0;
  bit stall_on = 1'b0;

  integer_string_parser i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver stalls in runs of random length
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_on   = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      stall_left = $urandom_range(1, 12);
    end else begin
      stall_left--;
    end
    out_stall <= stall_on;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_parses.size() == 0) begin
        $error("result transaction with no string pending: value %0d end_offset %0d",
               out_data.value, out_data.end_offset);
        error_count++;
      end else begin
        want = pending_parses.pop_front();
        if (out_data.value !== want.value) begin
          $error("value expected %0d actual %0d", want.value, out_data.value);
          error_count++;
        end
        if (out_data.end_offset !== want.end_offset) begin
          $error("end_offset expected %0d actual %0d", want.end_offset, out_data.end_offset);
          error_count++;
        end
      end
    end
  end

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "f") return 6'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 6'(c - "A" + 10);
    return NOT_A_DIGIT;
  endfunction

  function automatic void parse_char(input in_item_t it);
    logic [POS_W-1:0] nxt;
    logic [5:0]       d;
    bit               taken;
    out_item_t        res;
    nxt   = (scan_pos < POS_CAP) ? scan_pos + 1'b1 : POS_CAP;
    taken = 1'b0;
    if (scan_state == SCAN_BLANKS) begin
      if (it.ch == CH_SPACE || it.ch == CH_TAB || it.ch == CH_LF || it.ch == CH_CR) begin
        stop_pos = nxt;
        taken    = 1'b1;
      end else if (it.ch == CH_MINUS || it.ch == CH_PLUS) begin
        minus_seen = (it.ch == CH_MINUS);
        stop_pos   = nxt;
        scan_state = SCAN_SIGNED;
        taken      = 1'b1;
      end else begin
        scan_state = SCAN_SIGNED;
      end
    end
    // radix is chosen here, at the first character after blanks and sign; a later x may switch it to 16
    if (!taken && scan_state == SCAN_SIGNED) begin
      if (it.ch == CH_ZERO && (radix_setting == BASE_AUTO || radix_setting == BASE_HEX)) begin
        radix      = (radix_setting == BASE_AUTO) ? BASE_OCT : BASE_HEX;
        stop_pos   = nxt;
        scan_state = SCAN_ZERO;
        taken      = 1'b1;
      end else begin
        radix      = (radix_setting == BASE_AUTO) ? BASE_DEC : radix_setting;
        scan_state = SCAN_DIGITS;
      end
    end
    if (!taken && scan_state == SCAN_ZERO) begin
      if (it.ch == CH_X_LO || it.ch == CH_X_UP) begin
        radix    = BASE_HEX;
        stop_pos = nxt;
        taken    = 1'b1;
      end
      scan_state = SCAN_DIGITS;
    end
    if (!taken && scan_state == SCAN_DIGITS) begin
      d = digit_value(it.ch);
      if (d >= 6'(radix)) begin
        scan_state = SCAN_DONE;
      end else begin
        acc      = acc * VAL_W'(radix) + VAL_W'(d);
        stop_pos = nxt;
      end
    end
    scan_pos = nxt;
    if (it.last) begin
      res.value      = minus_seen ? -acc : acc;
      res.end_offset = stop_pos;
      pending_parses.push_back(res);
      scan_state = SCAN_BLANKS;
      minus_seen = 1'b0;
      acc        = '0;
      radix      = '0;
      scan_pos   = '0;
      stop_pos   = '0;
    end
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    in_item_t it;
    int       gap;
    it.ch   = c;
    it.last = fin;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    parse_char(it);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] s[$]);
    for (int i = 0; i < s.size(); i++) begin
      send_char(s[i], i == s.size() - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_parses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_base(input logic [BASE_W-1:0] b);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en     <= 1'b0;
    radix_setting = b;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(3) == 0) return blank_char();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] digit_char(input int v);
    if (v < 10) return 8'(CH_ZERO + v);
    if ($urandom_range(1) == 0) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  task automatic send_random_string();
    logic [7:0] s[$];
    int         limit;
    int         n;
    int         pick;
    s = {};
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) s.push_back(noise_char());
    end else begin
      repeat ($urandom_range(0, 3)) s.push_back(blank_char());
      pick = $urandom_range(0, 3);
      if (pick == 1) s.push_back(CH_PLUS);
      else if (pick == 2) s.push_back(CH_MINUS);
      limit = (radix_setting == BASE_AUTO) ? 10 :
              (radix_setting > BASE_HEX) ? 16 : int'(radix_setting);
      pick = $urandom_range(0, 3);
      if (pick != 0 && (radix_setting == BASE_AUTO || radix_setting == BASE_HEX ||
                        $urandom_range(7) == 0)) begin
        s.push_back(CH_ZERO);
        if (pick >= 2) s.push_back(pick == 2 ? CH_X_LO : CH_X_UP);
        if (radix_setting == BASE_AUTO) limit = (pick >= 2) ? 16 : 8;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 10);
      repeat (n) begin
        if ($urandom_range(19) == 0) s.push_back(noise_char());
        else s.push_back(digit_char($urandom_range(0, limit - 1)));
      end
      pick = $urandom_range(0, 2);
      if (pick == 1) s.push_back(CH_NUL);
      else if (pick == 2) s.push_back(noise_char());
      repeat ($urandom_range(0, 2)) s.push_back(noise_char());
    end
    if (s.size() == 0) s.push_back(noise_char());
    send_bytes(s);
  endtask

  task automatic test_directed();
    logic [7:0] s[$];
    gap_max   = 0;
    stall_pct = 0;
    set_base(BASE_DEC);
    s = '{CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_MINUS, "1", "2"};
    send_bytes(s);
    set_base(BASE_AUTO);
    s = '{CH_ZERO, CH_X_LO, "1", "F"};
    send_bytes(s);
    s = '{CH_ZERO};
    send_bytes(s);
    s = '{CH_ZERO, "7", "8"};
    send_bytes(s);
    set_base(BASE_HEX);
    s = '{CH_ZERO, CH_X_UP, "g"};
    send_bytes(s);
    s = '{"f", CH_NUL, "f"};
    send_bytes(s);
    set_base(BASE_W'(31));
    s = '{"f", "F", "9", 8'hff};
    send_bytes(s);
    set_base(BASE_W'(1));
    s = '{CH_ZERO, CH_ZERO, "1"};
    send_bytes(s);
    s = '{CH_SPACE, CH_MINUS};
    send_bytes(s);
  endtask

  task automatic test_long_strings();
    logic [7:0] s[$];
    gap_max   = 2;
    stall_pct = 30;
    set_base(BASE_HEX);
    // blanks, a sign, then digits that run past the position cap
    s = {};
    repeat (MAX_LEN / 2) s.push_back(blank_char());
    s.push_back(CH_MINUS);
    repeat (MAX_LEN / 2 + 8) s.push_back(digit_char(15));
    send_bytes(s);
  endtask

  task automatic test_random_strings();
    logic [BASE_W-1:0] bases[8];
    int                target;
    int                ph;
    bases = '{BASE_AUTO, BASE_DEC, BASE_HEX, BASE_W'(31), BASE_W'(1), BASE_W'(2), BASE_OCT,
              BASE_W'($urandom_range(0, 31))};
    for (ph = 0; ph < 8; ph++) begin
      gap_max   = (ph % 3 == 0) ? 0 : $urandom_range(1, 6);
      stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(20, 70);
      set_base(bases[ph]);
      target = items_sent + 200;
      while (items_sent < target) begin
        send_random_string();
        // at random, hold the sender until all results are back
        if ($urandom_range(29) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_strings();
    test_random_strings();
    wait_drained();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_parses.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
